// File: rtl/bitmap_id_allocator_defines.svh
// assertion macros used by the checker file
// no dependencies; expects clk_i and rst_ni in the using scope
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BIA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bia assertion failed");

// next-cycle implication, checked out of reset
`define BIA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bia assertion failed");

`endif

// File: rtl/bia_pkg.sv
// types, status codes and the free-bit encoder of the bitmap id allocator
// no dependencies
`timescale 1ns / 1ps

package bia_pkg;

  localparam int unsigned ByteBits = 8;
  localparam logic [7:0] ByteFull = 8'hFF;

  typedef enum logic [2:0] {
    ST_ID_GIVEN = 3'd0,
    ST_NOTHING  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_FREED    = 3'd4,
    ST_IGNORED  = 3'd5
  } status_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

  // lowest clear bit of a map byte (only meaningful for a byte that is not full)
  function automatic logic [2:0] lowest_free(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage

// File: rtl/bia_req_if.sv
// request channel of the bitmap id allocator: valid/ready plus payload
// no dependencies
`timescale 1ns / 1ps

interface bia_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [5:0]  count;
  logic [15:0] free_id;

  modport source (output valid, req_type, count, free_id, input ready);
  modport sink (input valid, req_type, count, free_id, output ready);
endinterface

// File: rtl/bia_rsp_if.sv
// result channel of the bitmap id allocator: valid/ready plus payload
// no dependencies
`timescale 1ns / 1ps

interface bia_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [12:0] alloc_id;
  logic        last;

  modport source (output valid, status, alloc_id, last, input ready);
  modport sink (input valid, status, alloc_id, last, output ready);
endinterface

// File: rtl/bitmap_id_allocator.sv
// bitmap first-fit id allocator, top level
// depends on bia_pkg, bia_req_if, bia_rsp_if and bia_map_ram
`timescale 1ns / 1ps

// Hands out numeric IDs 0..CAPACITY-1 (CAPACITY is NUM_IDS rounded up to a
// multiple of eight) from a byte-wide usage map held in one synchronous RAM.
// An allocate transfer with count n returns n results, each the lowest free
// ID at that moment, the last one flagged; a free transfer returns one
// result. Zero count, oversized batches (above MAX_BATCH or CAPACITY) and
// requests that cannot be met in full return a single status result and
// leave the map untouched. After reset the block runs a clearing pass of
// one map byte per cycle and takes no request until it is done. A
// status-only result is registered in the accept cycle; a free reads its
// map byte from the RAM, then writes it back; an allocate scans upward
// from a hint register that marks the lowest byte that may still hold a
// free ID, passing over full bytes and writing back one ID per byte update.
// The scan over full bytes at one RAM read per cycle is what sets the
// allocate time. One result register sits on the output; a request is
// taken only when that register is free or being emptied in the same cycle.
module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int unsigned NUM_IDS   = 8192,
  parameter int unsigned MAX_BATCH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bia_req_if.sink    req_i,
  bia_rsp_if.source  rsp_o
);

  localparam int unsigned MapBytes = (NUM_IDS + 7) / 8;
  localparam int unsigned Capacity = MapBytes * ByteBits;
  localparam int unsigned AW       = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int unsigned FTW      = $clog2(Capacity + 1);

  // controller states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_FREE  = 2'd2;
  localparam logic [1:0] S_ALLOC = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;      // clearing pass address
  logic [AW-1:0]  ptr_q, ptr_d;      // byte under work
  logic [AW-1:0]  hint_q, hint_d;    // every byte below this one is full
  logic [FTW-1:0] ft_q, ft_d;        // number of free IDs
  logic [5:0]     rem_q, rem_d;      // IDs still to hand out
  logic [2:0]     bit_q, bit_d;      // bit to clear on a free
  logic [7:0]     fwd_q, fwd_d;      // byte just written, reused for the next ID
  logic           fwdv_q, fwdv_d;

  // result register
  logic           out_valid_q;
  status_e        out_status_q;
  logic [12:0]    out_id_q;
  logic           out_last_q;

  logic           emit;
  status_e        e_status;
  logic [12:0]    e_id;
  logic           e_last;

  // ram port
  ram_ctl_t       ram_ctl;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  logic           slot_free;
  logic           fid_in_range;
  logic [AW-1:0]  fid_byte;
  logic [7:0]     cur_byte;
  logic [2:0]     low_bit;
  logic [31:0]    id_full;

  bia_map_ram #(
    .Depth (MapBytes),
    .AddrW (AW)
  ) u_map (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_free    = !out_valid_q || rsp_o.ready;
  assign fid_in_range = 32'(req_i.free_id) < Capacity;
  assign fid_byte     = AW'(32'(req_i.free_id) >> 3);
  // a byte just written is taken from the forward register, not the ram
  assign cur_byte     = fwdv_q ? fwd_q : ram_rdata;
  assign low_bit      = lowest_free(cur_byte);
  assign id_full      = (32'(ptr_q) << 3) | 32'(low_bit);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ptr_d     = ptr_q;
    hint_d    = hint_q;
    ft_d      = ft_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    fwd_d     = fwd_q;
    fwdv_d    = fwdv_q;
    ram_ctl   = '0;
    ram_waddr = ptr_q;
    ram_wdata = 8'h00;
    ram_raddr = ptr_q;
    emit      = 1'b0;
    e_status  = ST_ID_GIVEN;
    e_id      = '0;
    e_last    = 1'b1;
    req_i.ready = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // zero one map byte per cycle
        ram_ctl.wr_en = 1'b1;
        ram_waddr     = clr_q;
        if (clr_q == AW'(MapBytes - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        req_i.ready = slot_free;
        if (req_i.valid && slot_free) begin
          if (req_i.req_type) begin
            if (!fid_in_range) begin
              emit     = 1'b1;
              e_status = ST_IGNORED;
            end else begin
              ram_ctl.rd_en = 1'b1;
              ram_raddr     = fid_byte;
              ptr_d         = fid_byte;
              bit_d         = req_i.free_id[2:0];
              fwdv_d        = 1'b0;
              state_d       = S_FREE;
            end
          end else if (req_i.count == 6'd0) begin
            emit     = 1'b1;
            e_status = ST_NOTHING;
          end else if (32'(req_i.count) > MAX_BATCH || 32'(req_i.count) > Capacity) begin
            emit     = 1'b1;
            e_status = ST_TOO_LARGE;
          end else if (32'(ft_q) < 32'(req_i.count)) begin
            emit     = 1'b1;
            e_status = ST_NO_SPACE;
          end else begin
            // start the scan at the hint
            ram_ctl.rd_en = 1'b1;
            ram_raddr     = hint_q;
            ptr_d         = hint_q;
            rem_d         = req_i.count;
            fwdv_d        = 1'b0;
            state_d       = S_ALLOC;
          end
        end
      end

      S_FREE: begin
        if (slot_free) begin
          ram_ctl.wr_en = 1'b1;
          ram_wdata     = ram_rdata & ~(8'h01 << bit_q);
          if (ram_rdata[bit_q]) begin
            ft_d = ft_q + FTW'(1);
          end
          if (ptr_q < hint_q) begin
            hint_d = ptr_q;
          end
          emit     = 1'b1;
          e_status = ST_FREED;
          state_d  = S_IDLE;
        end
      end

      S_ALLOC: begin
        if (cur_byte == ByteFull) begin
          // full byte: move on, one read per cycle
          ptr_d         = ptr_q + AW'(1);
          ram_ctl.rd_en = 1'b1;
          ram_raddr     = ptr_q + AW'(1);
          fwdv_d        = 1'b0;
        end else if (slot_free) begin
          ram_ctl.wr_en = 1'b1;
          ram_wdata     = cur_byte | (8'h01 << low_bit);
          fwd_d         = cur_byte | (8'h01 << low_bit);
          fwdv_d        = 1'b1;
          ft_d          = ft_q - FTW'(1);
          rem_d         = rem_q - 6'd1;
          hint_d        = ptr_q;
          emit          = 1'b1;
          e_status      = ST_ID_GIVEN;
          e_id          = id_full[12:0];
          e_last        = (rem_q == 6'd1);
          if (rem_q == 6'd1) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      ft_q        <= FTW'(Capacity);
      rem_q       <= '0;
      fwdv_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      ft_q    <= ft_d;
      rem_q   <= rem_d;
      fwdv_q  <= fwdv_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    bit_q <= bit_d;
    fwd_q <= fwd_d;
    if (emit) begin
      out_status_q <= e_status;
      out_id_q     <= e_id;
      out_last_q   <= e_last;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.alloc_id = out_id_q;
  assign rsp_o.last     = out_last_q;

endmodule

// File: rtl/bia_map_ram.sv
// byte-wide map memory, one write and one registered read port
// depends on bia_pkg
`timescale 1ns / 1ps

module bia_map_ram
  import bia_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  ram_ctl_t         ctl_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bia_checker.sv
// port-level checker for the bitmap id allocator, bound to the top level
// depends on bia_pkg and bitmap_id_allocator_defines.svh
`timescale 1ns / 1ps
`include "bitmap_id_allocator_defines.svh"

module bia_checker
  import bia_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        req_type_i,
  input logic [5:0]  req_count_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [12:0] rsp_alloc_id_i,
  input logic        rsp_last_i
);

  // a stalled result stays offered
  `BIA_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  // no new request while a batch is still being handed out
  `BIA_ASSERT_IMP(a_no_req_mid_batch, rsp_valid_i && !rsp_last_i, !req_ready_i)

  // only a given id carries a nonzero id field
  `BIA_ASSERT_IMP(a_id_zero, rsp_valid_i && rsp_status_i != ST_ID_GIVEN,
                  rsp_alloc_id_i == 13'd0)

  // an empty allocate answers in the next cycle with a single flagged result
  `BIA_ASSERT_NXT(a_nothing, req_valid_i && req_ready_i && !req_type_i && req_count_i == 6'd0,
                  rsp_valid_i && rsp_status_i == ST_NOTHING && rsp_last_i)

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_type_i     (req_i.req_type),
  .req_count_i    (req_i.count),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_alloc_id_i (rsp_o.alloc_id),
  .rsp_last_i     (rsp_o.last)
);
